[rtl/core/ugb_pkg.sv]
package ugb_pkg;

  // Field widths
  localparam int unsigned ID_W     = 16;
  localparam int unsigned POS_W    = 24;
  localparam int unsigned CSIZE_W  = 16;
  localparam int unsigned GRID_W   = 13;
  localparam int unsigned CIDX_W   = 12;
  localparam int unsigned NSLOT_W  = 10;
  localparam int unsigned STATUS_W = 2;

  // Stream packing
  localparam int unsigned S_DATA_W = 64;
  localparam int unsigned M_DATA_W = 40;

  // Configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] REG_CELL_SIZE    = 2'd0;
  localparam logic [1:0] REG_GRID_COLUMNS = 2'd1;
  localparam logic [1:0] REG_GRID_ROWS    = 2'd2;

  localparam logic [CSIZE_W-1:0] CELL_SIZE_RESET    = 16'd2560;
  localparam logic [GRID_W-1:0]  GRID_COLUMNS_RESET = 13'd64;
  localparam logic [GRID_W-1:0]  GRID_ROWS_RESET    = 13'd64;

  // Default storage sizes
  localparam int unsigned MAX_CELLS_DEF  = 4096;
  localparam int unsigned POOL_DEPTH_DEF = 1024;

  // Epoch tag kept beside every chain head; tag zero marks a swept entry
  localparam int unsigned EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_OUTSIDE   = 2'd1,
    ST_POOL_FULL = 2'd2,
    ST_CLEARED   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_MUL,
    S_ADD,
    S_READ,
    S_LINK,
    S_DONE
  } state_t;

endpackage

[rtl/core/ugb_ram.sv]
module ugb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/uniform_grid_binning.sv]
// Uniform grid binning. Each insert request divides its signed Q16.8 position
// by the Q8.8 cell size on one restoring divider, one quotient bit per cycle,
// x then y. The cell index is then formed by one multiply and add, the cell's
// chain head is read from RAM and the new pool slot pushed. An insert that
// lands in the grid returns its result after the link step. An off-grid x
// returns after the x division, an off-grid y after the y division, and an
// index past the cell store or a full pool after the add. A clear, or any
// insert while the cell size is zero, goes straight to its result. s_tready
// stays low from acceptance until the cycle after the result is loaded, or
// until a due sweep ends. Chain heads carry an epoch tag, so a clear only
// bumps the epoch and empties the pool. After reset, and after every 255th
// clear, the head RAM is swept once with s_tready low (configuration writes
// are taken throughout). A result waiting on m_tready does not stop the next
// request being accepted.
module uniform_grid_binning #(
  parameter int unsigned MAX_CELLS  = ugb_pkg::MAX_CELLS_DEF,
  parameter int unsigned POOL_DEPTH = ugb_pkg::POOL_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ugb_pkg::APB_AW-1:0]    paddr,
  input  logic [ugb_pkg::APB_DW-1:0]    pwdata,
  output logic [ugb_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  // request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [15:0] particle_id, [39:16] pos_x, [63:40] pos_y
  input  logic [ugb_pkg::S_DATA_W-1:0]  s_tdata,
  // [0] action
  input  logic                          s_tuser,
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [11:0] bin_index, [21:12] node_slot, [22] has_prev, [32:23] prev_node, rest 0
  output logic [ugb_pkg::M_DATA_W-1:0]  m_tdata,
  // [1:0] status
  output logic [ugb_pkg::STATUS_W-1:0]  m_tuser
);

  localparam int unsigned CELL_AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned SLOT_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned FILL_W  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned HEAD_W  = ugb_pkg::EPOCH_W + SLOT_W;
  localparam int unsigned NODE_W  = ugb_pkg::ID_W + 1 + SLOT_W;
  localparam int unsigned POS_W   = ugb_pkg::POS_W;
  localparam int unsigned CNT_W   = $clog2(POS_W);
  localparam int unsigned GRID_W  = ugb_pkg::GRID_W;
  localparam int unsigned PROD_W  = 2 * GRID_W;
  localparam int unsigned IDX_W   = PROD_W + 1;

  function automatic logic [POS_W-1:0] magnitude(input logic [POS_W-1:0] v);
    magnitude = v[POS_W-1] ? (~v + POS_W'(1)) : v;
  endfunction

  // configuration
  logic [ugb_pkg::CSIZE_W-1:0] cell_edge;
  logic [GRID_W-1:0]           grid_columns;
  logic [GRID_W-1:0]           grid_rows;
  logic                        cfg_wr;

  // control
  ugb_pkg::state_t             state, state_next;
  logic [ugb_pkg::EPOCH_W-1:0] epoch;
  logic                        sweep_req;
  logic [CELL_AW-1:0]          sweep_cnt;
  logic                        sweep_last;
  logic [FILL_W-1:0]           pool_fill;
  logic                        pool_full;
  logic                        out_load;
  logic                        in_fire;

  // request fields
  logic                        in_action;
  logic [ugb_pkg::ID_W-1:0]    in_pid;
  logic [POS_W-1:0]            in_pos_x;
  logic [POS_W-1:0]            in_pos_y;

  // working registers
  logic [ugb_pkg::ID_W-1:0]    pid;
  logic [POS_W-1:0]            pos_y;
  logic                        phase;
  logic                        neg;
  logic [ugb_pkg::CSIZE_W-1:0] div_rem;
  logic [POS_W-1:0]            div_q;
  logic [CNT_W-1:0]            div_cnt;
  logic [GRID_W-1:0]           cx;
  logic [GRID_W-1:0]           cy;
  logic [PROD_W-1:0]           prod;
  logic [IDX_W-1:0]            idx;

  // divider step
  logic [ugb_pkg::CSIZE_W:0]   rem_sh;
  logic                        rem_ge;
  logic [ugb_pkg::CSIZE_W-1:0] rem_next;
  logic [POS_W-1:0]            div_q_next;

  logic                        coord_bad;
  logic [IDX_W-1:0]            idx_sum;
  logic                        idx_bad;

  // pending result
  ugb_pkg::status_t            res_status;
  logic [ugb_pkg::CIDX_W-1:0]  res_cell;
  logic [ugb_pkg::NSLOT_W-1:0] res_slot;
  logic                        res_has_prev;
  logic [ugb_pkg::NSLOT_W-1:0] res_prev;

  // head RAM
  logic                        head_we;
  logic [CELL_AW-1:0]          head_waddr;
  logic [HEAD_W-1:0]           head_wdata;
  logic [HEAD_W-1:0]           head_rdata;
  logic                        head_hit;
  logic [SLOT_W-1:0]           head_prev;
  logic [SLOT_W-1:0]           slot;
  logic [31:0]                 slot_ext;
  logic [31:0]                 prev_ext;

  // node RAM
  logic                        node_we;
  logic [NODE_W-1:0]           node_wdata;
  logic [NODE_W-1:0]           node_rdata;

  assign in_action = s_tuser;
  assign in_pid    = s_tdata[15:0];
  assign in_pos_x  = s_tdata[39:16];
  assign in_pos_y  = s_tdata[63:40];

  assign in_fire    = s_tvalid && s_tready;
  assign sweep_last = (sweep_cnt == CELL_AW'(MAX_CELLS - 1));
  assign pool_full  = (pool_fill >= FILL_W'(POOL_DEPTH));
  assign slot       = pool_fill[SLOT_W-1:0];

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      ugb_pkg::REG_CELL_SIZE:    prdata = 32'(cell_edge);
      ugb_pkg::REG_GRID_COLUMNS: prdata = 32'(grid_columns);
      ugb_pkg::REG_GRID_ROWS:    prdata = 32'(grid_rows);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_edge    <= ugb_pkg::CELL_SIZE_RESET;
      grid_columns <= ugb_pkg::GRID_COLUMNS_RESET;
      grid_rows    <= ugb_pkg::GRID_ROWS_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        ugb_pkg::REG_CELL_SIZE:    cell_edge    <= pwdata[ugb_pkg::CSIZE_W-1:0];
        ugb_pkg::REG_GRID_COLUMNS: grid_columns <= pwdata[GRID_W-1:0];
        ugb_pkg::REG_GRID_ROWS:    grid_rows    <= pwdata[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // shared restoring divider, one quotient bit per cycle
  assign rem_sh     = {div_rem, div_q[POS_W-1]};
  assign rem_ge     = (rem_sh >= {1'b0, cell_edge});
  assign rem_next   = rem_ge ? ugb_pkg::CSIZE_W'(rem_sh - {1'b0, cell_edge})
                             : rem_sh[ugb_pkg::CSIZE_W-1:0];
  assign div_q_next = {div_q[POS_W-2:0], rem_ge};

  // a negative coordinate of at least one cell is off the grid
  assign coord_bad = (neg && (div_q != '0)) ||
                     (div_q >= POS_W'(phase ? grid_rows : grid_columns));

  assign idx_sum = IDX_W'(prod) + IDX_W'(cx);
  assign idx_bad = (idx_sum >= IDX_W'(MAX_CELLS));

  assign head_hit  = (head_rdata[HEAD_W-1 -: ugb_pkg::EPOCH_W] == epoch);
  assign head_prev = head_hit ? head_rdata[SLOT_W-1:0] : '0;
  assign slot_ext  = 32'(slot);
  assign prev_ext  = 32'(head_prev);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ugb_pkg::S_SWEEP: begin
        if (sweep_last) state_next = ugb_pkg::S_IDLE;
      end
      ugb_pkg::S_IDLE: begin
        if (s_tvalid) begin
          if (in_action == ugb_pkg::ACT_CLEAR || cell_edge == '0) begin
            state_next = ugb_pkg::S_DONE;
          end else begin
            state_next = ugb_pkg::S_DIV;
          end
        end
      end
      ugb_pkg::S_DIV: begin
        if (div_cnt == CNT_W'(POS_W - 1)) state_next = ugb_pkg::S_CHECK;
      end
      ugb_pkg::S_CHECK: begin
        if (coord_bad)  state_next = ugb_pkg::S_DONE;
        else if (!phase) state_next = ugb_pkg::S_DIV;
        else             state_next = ugb_pkg::S_MUL;
      end
      ugb_pkg::S_MUL: state_next = ugb_pkg::S_ADD;
      ugb_pkg::S_ADD: begin
        if (idx_bad || pool_full) state_next = ugb_pkg::S_DONE;
        else                      state_next = ugb_pkg::S_READ;
      end
      ugb_pkg::S_READ: state_next = ugb_pkg::S_LINK;
      ugb_pkg::S_LINK: state_next = ugb_pkg::S_DONE;
      ugb_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = sweep_req ? ugb_pkg::S_SWEEP : ugb_pkg::S_IDLE;
        end
      end
      default: state_next = ugb_pkg::S_SWEEP;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready   = (state == ugb_pkg::S_IDLE);
    out_load   = (state == ugb_pkg::S_DONE) && (!m_tvalid || m_tready);
    head_we    = (state == ugb_pkg::S_SWEEP) || (state == ugb_pkg::S_LINK);
    node_we    = (state == ugb_pkg::S_LINK);
    head_waddr = (state == ugb_pkg::S_SWEEP) ? sweep_cnt : idx[CELL_AW-1:0];
    head_wdata = (state == ugb_pkg::S_SWEEP) ? '0 : {epoch, slot};
    node_wdata = {pid, head_hit, head_prev};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ugb_pkg::S_SWEEP;
      epoch     <= ugb_pkg::EPOCH_FIRST;
      sweep_req <= 1'b0;
      sweep_cnt <= '0;
      pool_fill <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ugb_pkg::S_SWEEP) begin
        if (sweep_last) begin
          sweep_cnt <= '0;
          epoch     <= ugb_pkg::EPOCH_FIRST;
          sweep_req <= 1'b0;
        end else begin
          sweep_cnt <= sweep_cnt + CELL_AW'(1);
        end
      end
      if (in_fire && in_action == ugb_pkg::ACT_CLEAR) begin
        pool_fill <= '0;
        if (epoch == ugb_pkg::EPOCH_LAST) sweep_req <= 1'b1;
        else                              epoch     <= epoch + ugb_pkg::EPOCH_W'(1);
      end
      if (state == ugb_pkg::S_LINK) pool_fill <= pool_fill + FILL_W'(1);
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ugb_pkg::S_IDLE: begin
        if (s_tvalid) begin
          pid          <= in_pid;
          pos_y        <= in_pos_y;
          phase        <= 1'b0;
          neg          <= in_pos_x[POS_W-1];
          div_q        <= magnitude(in_pos_x);
          div_rem      <= '0;
          div_cnt      <= '0;
          res_status   <= (in_action == ugb_pkg::ACT_CLEAR) ? ugb_pkg::ST_CLEARED
                                                            : ugb_pkg::ST_OUTSIDE;
          res_cell     <= '0;
          res_slot     <= '0;
          res_has_prev <= 1'b0;
          res_prev     <= '0;
        end
      end
      ugb_pkg::S_DIV: begin
        div_rem <= rem_next;
        div_q   <= div_q_next;
        div_cnt <= div_cnt + CNT_W'(1);
      end
      ugb_pkg::S_CHECK: begin
        if (!phase) begin
          cx      <= div_q[GRID_W-1:0];
          phase   <= 1'b1;
          neg     <= pos_y[POS_W-1];
          div_q   <= magnitude(pos_y);
          div_rem <= '0;
          div_cnt <= '0;
        end else begin
          cy <= div_q[GRID_W-1:0];
        end
      end
      ugb_pkg::S_MUL: begin
        prod <= cy * grid_columns;
      end
      ugb_pkg::S_ADD: begin
        idx <= idx_sum;
        if (!idx_bad && pool_full) begin
          res_status <= ugb_pkg::ST_POOL_FULL;
          res_cell   <= idx_sum[ugb_pkg::CIDX_W-1:0];
        end
      end
      ugb_pkg::S_LINK: begin
        res_status   <= ugb_pkg::ST_INSERTED;
        res_cell     <= idx[ugb_pkg::CIDX_W-1:0];
        res_slot     <= slot_ext[ugb_pkg::NSLOT_W-1:0];
        res_has_prev <= head_hit;
        res_prev     <= prev_ext[ugb_pkg::NSLOT_W-1:0];
      end
      default: ;
    endcase
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {7'd0, res_prev, res_has_prev, res_slot, res_cell};
    end
  end

  // chain heads, tagged with the epoch they were written in
  ugb_ram #(
    .WIDTH (HEAD_W),
    .DEPTH (MAX_CELLS)
  ) u_head_ram (
    .clk     (clk),
    .wr_en   (head_we),
    .wr_addr (head_waddr),
    .wr_data (head_wdata),
    .rd_addr (idx[CELL_AW-1:0]),
    .rd_data (head_rdata)
  );

  // node pool: particle id, link valid, link
  ugb_ram #(
    .WIDTH (NODE_W),
    .DEPTH (POOL_DEPTH)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (node_we),
    .wr_addr (slot),
    .wr_data (node_wdata),
    .rd_addr (slot),
    .rd_data (node_rdata)
  );

endmodule
